### hdl/dpkd_pkg.sv
// dpkd_pkg: shared types and constants for the der public key decoder
// holds the parse phase enum, payload structs and the store port structs
// no dependencies
package dpkd_pkg;

  localparam int unsigned FIELD_BYTES     = 28;
  localparam int unsigned MAX_INPUT_BYTES = 512;

  localparam int unsigned CNT_W   = $clog2(MAX_INPUT_BYTES + 1);
  localparam int unsigned END_W   = $clog2(MAX_INPUT_BYTES + 129);
  localparam int unsigned SLOT_W  = $clog2(FIELD_BYTES + 1);
  localparam int unsigned ADDR_W  = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;
  localparam int unsigned RIDX_W  = $clog2(2 * FIELD_BYTES);

  localparam logic [7:0] TAG_SEQ     = 8'h30;
  localparam logic [7:0] TAG_INT     = 8'h02;
  localparam logic [7:0] TAG_BITS    = 8'h03;
  localparam logic [7:0] SIZE_BYTE   = 8'(FIELD_BYTES & 8'hFF);

  typedef enum logic [3:0] {
    PH_SEQ_TAG, PH_SEQ_LEN, PH_BIT_TAG, PH_BIT_LEN, PH_BIT_BODY,
    PH_SZ_TAG, PH_SZ_LEN, PH_SZ_VAL, PH_X_TAG, PH_X_LEN, PH_X_BODY,
    PH_Y_TAG, PH_Y_LEN, PH_Y_BODY, PH_DONE
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic       coordinate;
    logic [4:0] byte_index;
    logic [7:0] coord_byte;
    logic       run_end;
  } out_item_t;

  // write side of the coordinate stores
  typedef struct packed {
    logic              clr;
    logic              put;
    logic              sel;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } st_wr_t;

  typedef struct packed {
    logic              sel;
    logic [ADDR_W-1:0] addr;
  } st_rd_t;

  typedef struct packed {
    logic done;
    logic ok;
  } run_t;

endpackage

### hdl/der_public_key_decoder_core.sv
// der_public_key_decoder_core: streaming decoder of an encoded ec public key
// input bytes are taken one per cycle while in_stall_o is low; the final byte's results start on the next cycle
// a good run gives 2*FIELD_BYTES words (56), one per cycle when not stalled; a bad one gives one
// input is stalled while results drain, so a new run's bytes are taken only after the last word is taken
// asynchronous active-low reset returns the parser to the sequence tag and empties both stores
// depends on dpkd_pkg, dpkd_parser, dpkd_store, dpkd_emitter
module der_public_key_decoder_core import dpkd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic       busy;
  logic       accept;
  st_wr_t     st_wr;
  st_rd_t     st_rd;
  run_t       run;
  logic [7:0] rd_data;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  dpkd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .st_wr_o  (st_wr),
    .run_o    (run)
  );

  dpkd_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (st_wr),
    .rd_i      (st_rd),
    .rd_data_o (rd_data)
  );

  dpkd_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_i       (run),
    .rd_o        (st_rd),
    .rd_data_i   (rd_data),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### hdl/dpkd_parser.sv
// dpkd_parser: per-byte tlv parse state and extent checks
// drives the coordinate store writes and reports the run outcome on the final byte
// depends on dpkd_pkg
module dpkd_parser import dpkd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output st_wr_t   st_wr_o,
  output run_t     run_o
);

  phase_e            phase_q, phase_d;
  logic [6:0]        rem_q, rem_d;
  logic [CNT_W-1:0]  seen_q, seen_d;
  logic [CNT_W-1:0]  req_end_q, req_end_d;
  logic              failed_q, failed_d;
  logic              first_q, first_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic [7:0]        b;
  logic [END_W-1:0]  ext_end;
  logic              len_ok;
  logic [6:0]        vsize;
  logic [SLOT_W-1:0] slot_base;
  logic              fail_n;
  logic              is_x;

  assign b         = item_i.data_byte;
  assign ext_end   = END_W'(seen_q) + END_W'(1) + END_W'(b[6:0]);
  assign len_ok    = !b[7] && (ext_end <= END_W'(MAX_INPUT_BYTES));
  assign vsize     = rem_q - 7'(b == 8'h00);
  assign slot_base = SLOT_W'(FIELD_BYTES) - vsize[SLOT_W-1:0];
  assign is_x      = (phase_q == PH_X_BODY);

  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    seen_d    = seen_q;
    req_end_d = req_end_q;
    first_d   = first_q;
    slot_d    = slot_q;
    fail_n    = 1'b0;
    st_wr_o   = '0;
    st_wr_o.sel  = !is_x;
    st_wr_o.data = b;

    if (!failed_q) begin
      if (seen_q >= CNT_W'(MAX_INPUT_BYTES)) begin
        fail_n = 1'b1;
      end else begin
        seen_d = seen_q + CNT_W'(1);
        unique case (phase_q)
          PH_SEQ_TAG: begin
            if (b != TAG_SEQ) fail_n = 1'b1;
            else phase_d = PH_SEQ_LEN;
          end
          PH_SEQ_LEN, PH_BIT_LEN, PH_SZ_LEN, PH_X_LEN, PH_Y_LEN: begin
            if (!len_ok) begin
              fail_n = 1'b1;
            end else begin
              if (ext_end > END_W'(req_end_q)) req_end_d = ext_end[CNT_W-1:0];
              rem_d = b[6:0];
              unique case (phase_q)
                PH_SEQ_LEN: phase_d = PH_BIT_TAG;
                PH_BIT_LEN: phase_d = (b[6:0] == 7'd0) ? PH_SZ_TAG : PH_BIT_BODY;
                PH_SZ_LEN: begin
                  if (b != 8'h01) fail_n = 1'b1;
                  else phase_d = PH_SZ_VAL;
                end
                PH_X_LEN: begin
                  if (b == 8'h00) fail_n = 1'b1;
                  else begin
                    first_d = 1'b1;
                    phase_d = PH_X_BODY;
                  end
                end
                default: begin
                  if (b == 8'h00) fail_n = 1'b1;
                  else begin
                    first_d = 1'b1;
                    phase_d = PH_Y_BODY;
                  end
                end
              endcase
            end
          end
          PH_BIT_TAG: begin
            if (b != TAG_BITS) fail_n = 1'b1;
            else phase_d = PH_BIT_LEN;
          end
          PH_BIT_BODY: begin
            rem_d = rem_q - 7'd1;
            if (rem_d == 7'd0) phase_d = PH_SZ_TAG;
          end
          PH_SZ_TAG: begin
            if (b != TAG_INT) fail_n = 1'b1;
            else phase_d = PH_SZ_LEN;
          end
          PH_SZ_VAL: begin
            if (b != SIZE_BYTE) fail_n = 1'b1;
            else phase_d = PH_X_TAG;
          end
          PH_X_TAG: begin
            if (b != TAG_INT) fail_n = 1'b1;
            else phase_d = PH_X_LEN;
          end
          PH_Y_TAG: begin
            if (b != TAG_INT) fail_n = 1'b1;
            else phase_d = PH_Y_LEN;
          end
          PH_X_BODY, PH_Y_BODY: begin
            if (first_q) begin
              // first value byte: a leading zero is stripped, value right-aligned
              if (vsize > 7'(FIELD_BYTES)) begin
                fail_n = 1'b1;
              end else begin
                st_wr_o.clr = 1'b1;
                first_d     = 1'b0;
                slot_d      = slot_base;
                if (b != 8'h00) begin
                  st_wr_o.put  = 1'b1;
                  st_wr_o.addr = slot_base[ADDR_W-1:0];
                  slot_d       = slot_base + SLOT_W'(1);
                end
              end
            end else if (slot_q < SLOT_W'(FIELD_BYTES)) begin
              st_wr_o.put  = 1'b1;
              st_wr_o.addr = slot_q[ADDR_W-1:0];
              slot_d       = slot_q + SLOT_W'(1);
            end
            if (!fail_n) begin
              rem_d = rem_q - 7'd1;
              if (rem_d == 7'd0) begin
                first_d = 1'b1;
                phase_d = is_x ? PH_Y_TAG : PH_DONE;
              end
            end
          end
          default: ;
        endcase
      end
    end

    failed_d  = failed_q | fail_n;
    run_o.done = accept_i && item_i.final_byte;
    run_o.ok   = !failed_d && (phase_d == PH_DONE) && (seen_d >= req_end_d);

    if (!accept_i) begin
      st_wr_o.clr = 1'b0;
      st_wr_o.put = 1'b0;
    end

    // end of run: back to the state after reset, stores keep their contents
    if (run_o.done) begin
      phase_d   = PH_SEQ_TAG;
      rem_d     = '0;
      seen_d    = '0;
      req_end_d = '0;
      failed_d  = 1'b0;
      first_d   = 1'b1;
      slot_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SEQ_TAG;
      rem_q     <= '0;
      seen_q    <= '0;
      req_end_q <= '0;
      failed_q  <= 1'b0;
      first_q   <= 1'b1;
      slot_q    <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      rem_q     <= rem_d;
      seen_q    <= seen_d;
      req_end_q <= req_end_d;
      failed_q  <= failed_d;
      first_q   <= first_d;
      slot_q    <= slot_d;
    end
  end

  a_final_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_o.done |=> (phase_q == PH_SEQ_TAG) && (seen_q == '0) && !failed_q)
    else $error("parse state not restored after final byte");

  a_failed_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> !st_wr_o.put && !st_wr_o.clr)
    else $error("store written after the run failed");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_wr_o.put |-> (32'(st_wr_o.addr) < FIELD_BYTES))
    else $error("store write beyond field width");

endmodule

### hdl/dpkd_store.sv
// dpkd_store: x and y coordinate stores with per-entry valid bits
// an entry that is not valid reads as zero; depends on dpkd_pkg
module dpkd_store import dpkd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  st_wr_t     wr_i,
  input  st_rd_t     rd_i,
  output logic [7:0] rd_data_o
);

  logic [7:0]             x_mem_q [FIELD_BYTES];
  logic [7:0]             y_mem_q [FIELD_BYTES];
  logic [FIELD_BYTES-1:0] x_vld_q, x_vld_d;
  logic [FIELD_BYTES-1:0] y_vld_q, y_vld_d;

  always_comb begin
    x_vld_d = x_vld_q;
    y_vld_d = y_vld_q;
    if (wr_i.clr) begin
      if (wr_i.sel) y_vld_d = '0;
      else x_vld_d = '0;
    end
    if (wr_i.put) begin
      if (wr_i.sel) y_vld_d[wr_i.addr] = 1'b1;
      else x_vld_d[wr_i.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q <= '0;
      y_vld_q <= '0;
    end else begin
      x_vld_q <= x_vld_d;
      y_vld_q <= y_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.put) begin
      if (wr_i.sel) y_mem_q[wr_i.addr] <= wr_i.data;
      else x_mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_comb begin
    if (rd_i.sel) rd_data_o = y_vld_q[rd_i.addr] ? y_mem_q[rd_i.addr] : 8'h00;
    else rd_data_o = x_vld_q[rd_i.addr] ? x_mem_q[rd_i.addr] : 8'h00;
  end

endmodule

### hdl/dpkd_emitter.sv
// dpkd_emitter: result register and sequencing of the coordinate words
// sends x then y high byte first, or one error word; depends on dpkd_pkg
module dpkd_emitter import dpkd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  run_t       run_i,
  output st_rd_t     rd_o,
  input  logic [7:0] rd_data_i,
  output logic       busy_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  logic              vld_q;
  logic [RIDX_W-1:0] idx_q, idx_n;
  out_item_t         out_q, out_d;
  logic              take;
  logic              start;
  logic              is_y;
  logic [4:0]        k;

  assign take  = vld_q && !out_stall_i;
  assign start = run_i.done;
  assign idx_n = start ? '0 : idx_q + RIDX_W'(1);
  assign is_y  = (32'(idx_n) >= FIELD_BYTES);
  assign k     = is_y ? 5'(32'(idx_n) - FIELD_BYTES) : 5'(idx_n);

  // x is complete before the final byte, so reading x[0] at start is safe
  assign rd_o.sel  = is_y;
  assign rd_o.addr = k[ADDR_W-1:0];

  always_comb begin
    out_d.status     = 1'b0;
    out_d.coordinate = is_y;
    out_d.byte_index = k;
    out_d.coord_byte = rd_data_i;
    out_d.run_end    = (32'(idx_n) == 2 * FIELD_BYTES - 1);
    if (start && !run_i.ok) begin
      out_d = '0;
      out_d.status  = 1'b1;
      out_d.run_end = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (start) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (take) begin
      vld_q <= !out_q.run_end;
      idx_q <= idx_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start || (take && !out_q.run_end)) out_q <= out_d;
  end

  assign busy_o      = vld_q;
  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !vld_q)
    else $error("run finished while results still pending");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && out_q.status |-> out_q.run_end && (out_q.coord_byte == 8'h00))
    else $error("error result is not a single word");

  a_last_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && out_q.run_end |=> !vld_q)
    else $error("results continue after the last word");

endmodule
